[hdl/pmit_pkg.sv]
// ----------------------------------------------------------------------------
// pmit_pkg
// shared types and constants of the per-client minimum interval tracker
// ----------------------------------------------------------------------------
package pmit_pkg;

  localparam int ID_BITS    = 64;
  localparam int GAP_BITS   = 48;
  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 56;

  // operation codes carried in tuser
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // result beat, lowest bit first: was_known, estimate_valid, best_gap, table_full
  typedef struct packed {
    logic                table_full;
    logic [GAP_BITS-1:0] best_gap;
    logic                estimate_valid;
    logic                was_known;
  } result_t;

endpackage

[hdl/pmit_ram.sv]
// ----------------------------------------------------------------------------
// pmit_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pmit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pmit_sub.sv]
// ----------------------------------------------------------------------------
// pmit_sub
// shared subtract and compare unit: difference and borrow of a minus b
// ----------------------------------------------------------------------------
module pmit_sub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  logic [W:0] res;

  assign res      = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = res[W-1:0];
  assign borrow_o = res[W];

endmodule

[hdl/per_id_min_interval_tracker.sv]
// ----------------------------------------------------------------------------
// per_id_min_interval_tracker
// per-client table of last arrival time and smallest inter-arrival gap
//
// usage:
//   slave beats carry one item: tuser is the operation (arrival or query),
//   tdata the client id and the arrival time. every item gives exactly one
//   master beat with was_known, estimate_valid, best_gap and table_full.
//   the table holds TABLE_ENTRIES clients, filled from entry 0 upward and
//   never freed, so a fill count marks the used entries.
// timing:
//   an item scans the used entries one per cycle through a single ram read
//   port; a known client's arrival then goes through the shared subtract
//   unit in two steps (gap, then compare).
//   the input is ready only while no item is in work.
// reset:
//   the table reads as empty at once, no clearing pass is needed.
// stall:
//   a result waits in the output register; the next item is accepted and
//   worked on meanwhile, and holds at its end until that register frees.
// ----------------------------------------------------------------------------
module per_id_min_interval_tracker
  import pmit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int TIME_BITS     = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // client_id, arrival_time
  input  logic                   s_axis_tuser_i,  // operation
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // was_known, estimate_valid,
                                                  // best_gap, table_full
);

  localparam int TW = (TIME_BITS < GAP_BITS) ? TIME_BITS : GAP_BITS;
  localparam int WW = ID_BITS + 2 * TW;
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_WB
  } state_e;

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [TW-1:0]      t_q, t_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [AW-1:0]      ent_q, ent_d;
  logic [TW-1:0]      last_q, last_d;
  logic [TW-1:0]      best_q, best_d;
  logic [TW-1:0]      gap_q, gap_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WW-1:0]      ram_wdata, ram_rdata;
  logic [ID_BITS-1:0] rd_client;
  logic [TW-1:0]      rd_last, rd_best;
  logic [TW-1:0]      sub_a, sub_b, sub_diff;
  logic               sub_borrow;
  logic               hit, can_fin;
  logic [TW-1:0]      new_best;

  pmit_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pmit_sub #(
    .W (TW)
  ) u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign rd_client = ram_rdata[WW-1 -: ID_BITS];
  assign rd_last   = ram_rdata[2*TW-1:TW];
  assign rd_best   = ram_rdata[TW-1:0];
  assign hit       = pend_q && (rd_client == id_q);
  assign can_fin   = !out_valid_q || m_axis_tready_i;
  assign new_best  = sub_borrow ? gap_q : best_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    t_d         = t_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    ent_d       = ent_q;
    last_d      = last_q;
    best_d      = best_q;
    gap_d       = gap_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = ent_q;
    ram_wdata   = {id_q, t_q, t_q};
    ram_re      = 1'b0;
    ram_raddr   = scan_q[AW-1:0];
    sub_a       = t_q;
    sub_b       = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = s_axis_tuser_i;
          id_d    = s_axis_tdata_i[ID_BITS-1:0];
          t_d     = s_axis_tdata_i[ID_BITS +: TW];
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op_q == OP_QUERY) begin
            if (can_fin) begin
              res_d.was_known      = 1'b1;
              res_d.estimate_valid = 1'b1;
              res_d.best_gap       = GAP_BITS'(rd_best);
              res_d.table_full     = 1'b0;
              out_valid_d          = 1'b1;
              state_d              = S_IDLE;
            end
          end else begin
            last_d  = rd_last;
            best_d  = rd_best;
            ent_d   = rd_idx_q;
            state_d = S_UPD;
          end
        end else if (scan_q < count_q) begin
          ram_re   = 1'b1;
          rd_idx_d = scan_q[AW-1:0];
          pend_d   = 1'b1;
          scan_d   = CW'(scan_q + 1'b1);
        end else if (can_fin) begin
          res_d       = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (op_q == OP_ARRIVAL) begin
            if (count_q == CW'(TABLE_ENTRIES)) begin
              res_d.table_full = 1'b1;
            end else begin
              ram_we               = 1'b1;
              ram_waddr            = count_q[AW-1:0];
              ram_wdata            = {id_q, t_q, t_q};
              count_d              = CW'(count_q + 1'b1);
              res_d.estimate_valid = 1'b1;
              res_d.best_gap       = GAP_BITS'(t_q);
            end
          end
        end
      end
      S_UPD: begin
        sub_a   = t_q;
        sub_b   = last_q;
        gap_d   = sub_borrow ? '0 : sub_diff;
        state_d = S_WB;
      end
      S_WB: begin
        sub_a = gap_q;
        sub_b = best_q;
        if (can_fin) begin
          ram_we               = 1'b1;
          ram_waddr            = ent_q;
          ram_wdata            = {id_q, t_q, new_best};
          res_d.was_known      = 1'b1;
          res_d.estimate_valid = 1'b1;
          res_d.best_gap       = GAP_BITS'(new_best);
          res_d.table_full     = 1'b0;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ARRIVAL;
      id_q        <= '0;
      t_q         <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      rd_idx_q    <= '0;
      ent_q       <= '0;
      last_q      <= '0;
      best_q      <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      id_q        <= id_d;
      t_q         <= t_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
      ent_q       <= ent_d;
      last_q      <= last_d;
      best_q      <= best_d;
      gap_q       <= gap_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - $bits(result_t))'(0), res_q};

  // fill count stays within the table
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // the fill count only grows, by one entry at a time
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("fill count moved by more than one");

  // a result never claims both a stored estimate and a full table
  a_full_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.table_full && (res_q.estimate_valid || res_q.was_known)))
    else $error("table full flagged together with an estimate");

  // the table is written only while an item is in work
  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("table write while idle");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for per_id_min_interval_tracker
//
// a short table of directed items covers the empty table, extreme ids and
// timestamps, backward time, absent queries and the table running full; a
// random part then drives arrivals and queries mostly on clients held in
// the table, with small forward time steps, some backward jumps and new ids
// that get dropped. every result beat is checked field by field against an
// in-bench model of the table or, on typed rows, a listed result, under
// several sender and receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import pmit_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int RANDOM_ITEMS   = 450;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 500000;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic        op;
    logic [63:0] id;
    logic [47:0] t;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // client_id, arrival_time
  logic                   s_axis_tuser_i;   // operation
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // was_known, estimate_valid,
                                            // best_gap, table_full

  // model of the client table
  logic        tbl_used   [ENTRIES];
  logic [63:0] tbl_client [ENTRIES];
  logic [47:0] tbl_last   [ENTRIES];
  logic [47:0] tbl_best   [ENTRIES];

  result_t     gap_results_q[$];
  stim_row_t   directed_q[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_off_req   = 1'b0;
  int  errors         = 0;
  int  cycles         = 0;
  int  n_arrivals     = 0;
  int  n_queries      = 0;
  int  n_results      = 0;
  int  n_full         = 0;
  int  n_backward     = 0;
  int  n_absent       = 0;

  per_id_min_interval_tracker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic result_t mk_res(logic known, logic valid, logic [47:0] gap, logic full);
    result_t r;
    r.was_known      = known;
    r.estimate_valid = valid;
    r.best_gap       = gap;
    r.table_full     = full;
    return r;
  endfunction

  // one item against the table model, state updated in place
  function automatic result_t track_interval(logic op, logic [63:0] id, logic [47:0] t);
    result_t     r;
    int          hit;
    int          slot;
    logic [47:0] gap;
    r    = '0;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_used[i] && tbl_client[i] == id) hit = i;
      if (slot < 0 && !tbl_used[i]) slot = i;
    end
    if (hit >= 0) begin
      r.was_known      = 1'b1;
      r.estimate_valid = 1'b1;
      if (op == OP_ARRIVAL) begin
        if (t < tbl_last[hit]) n_backward++;
        gap = (t >= tbl_last[hit]) ? t - tbl_last[hit] : '0;
        if (gap < tbl_best[hit]) tbl_best[hit] = gap;
        tbl_last[hit] = t;
      end
      r.best_gap = tbl_best[hit];
    end else if (op == OP_ARRIVAL) begin
      if (slot >= 0) begin
        tbl_used[slot]   = 1'b1;
        tbl_client[slot] = id;
        tbl_last[slot]   = t;
        tbl_best[slot]   = t;
        r.estimate_valid = 1'b1;
        r.best_gap       = t;
      end else begin
        r.table_full = 1'b1;
        n_full++;
      end
    end else begin
      n_absent++;
    end
    return r;
  endfunction

  task automatic add_row(logic op, logic [63:0] id, logic [47:0] t, bit typed,
                         result_t res);
    stim_row_t row;
    row.op    = op;
    row.id    = id;
    row.t     = t;
    row.typed = typed;
    row.res   = res;
    directed_q.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge after the beat
  task automatic send_item(stim_row_t row);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= row.op;
    s_axis_tdata_i  <= {row.t, row.id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = track_interval(row.op, row.id, row.t);
    if (row.op == OP_ARRIVAL) n_arrivals++;
    else n_queries++;
    gap_results_q.push_back(row.typed ? row.res : predicted);
    @(negedge clk_i);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t   row;
    int          pick;
    int          k;
    logic [47:0] step;
    pick      = $urandom_range(99);
    k         = $urandom_range(ENTRIES - 1);
    row.typed = 1'b0;
    row.res   = '0;
    row.id    = {$urandom, $urandom};
    row.t     = {16'($urandom), $urandom};
    if (pick < 60) begin
      row.op = OP_ARRIVAL;
      row.id = tbl_client[k];
      step   = 48'($urandom_range(0, 60));
      case ($urandom_range(19))
        0:       row.t = tbl_last[k] - step - 48'd1;
        1:       ;
        default: row.t = tbl_last[k] + step;
      endcase
    end else if (pick < 76) begin
      row.op = OP_QUERY;
      row.id = tbl_client[k];
    end else if (pick < 88) begin
      row.op = OP_QUERY;
    end else begin
      row.op = OP_ARRIVAL;
    end
    return row;
  endfunction

  // receiver side
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      n_results++;
      if (gap_results_q.size() == 0) begin
        $display("%0t: unexpected result beat %0h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = gap_results_q.pop_front();
        if (got.was_known !== want.was_known) begin
          $display("%0t: was_known expected %0b got %0b", $time, want.was_known,
                   got.was_known);
          errors++;
        end
        if (got.estimate_valid !== want.estimate_valid) begin
          $display("%0t: estimate_valid expected %0b got %0b", $time,
                   want.estimate_valid, got.estimate_valid);
          errors++;
        end
        if (got.best_gap !== want.best_gap) begin
          $display("%0t: best_gap expected %0h got %0h", $time, want.best_gap,
                   got.best_gap);
          errors++;
        end
        if (got.table_full !== want.table_full) begin
          $display("%0t: table_full expected %0b got %0b", $time, want.table_full,
                   got.table_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, gap_results_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        phase;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = OP_ARRIVAL;
    s_axis_tdata_i  = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;

    add_row(OP_QUERY,   64'd0, 48'd0, 1'b1, mk_res(1'b0, 1'b0, 48'd0, 1'b0));
    add_row(OP_ARRIVAL, 64'd0, 48'd0, 1'b1, mk_res(1'b0, 1'b1, 48'd0, 1'b0));
    add_row(OP_ARRIVAL, '1,    T_MAX, 1'b1, mk_res(1'b0, 1'b1, T_MAX, 1'b0));
    // time going backwards clamps the gap
    add_row(OP_ARRIVAL, '1,    48'd5, 1'b1, mk_res(1'b1, 1'b1, 48'd0, 1'b0));
    add_row(OP_ARRIVAL, 64'd0, 48'd1000, 1'b0, '0);
    add_row(OP_ARRIVAL, 64'h5555_5555_5555_5555, 48'd100, 1'b1,
            mk_res(1'b0, 1'b1, 48'd100, 1'b0));
    add_row(OP_ARRIVAL, 64'h5555_5555_5555_5555, 48'd130, 1'b0, '0);
    add_row(OP_ARRIVAL, 64'h5555_5555_5555_5555, 48'd200, 1'b0, '0);
    // query ignores the time field
    add_row(OP_QUERY,   64'h5555_5555_5555_5555, T_MAX, 1'b0, '0);
    add_row(OP_QUERY,   64'hAAAA_AAAA_AAAA_AAAA, T_MAX, 1'b1,
            mk_res(1'b0, 1'b0, 48'd0, 1'b0));
    for (int i = 0; i < ENTRIES - 3; i++)
      add_row(OP_ARRIVAL, {32'hA5A5_0000 + i, 32'h0F0F_0000 ^ i}, 48'(i * 7 + 3), 1'b1,
              mk_res(1'b0, 1'b1, 48'(i * 7 + 3), 1'b0));
    // table full drops the new client
    add_row(OP_ARRIVAL, 64'h0123_4567_89AB_CDEF, 48'd77, 1'b1,
            mk_res(1'b0, 1'b0, 48'd0, 1'b1));
    add_row(OP_QUERY,   64'h0123_4567_89AB_CDEF, 48'd0,  1'b1,
            mk_res(1'b0, 1'b0, 48'd0, 1'b0));

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_q[i]) send_item(directed_q[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = i * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (i == 30) hold_off_req = 1'b1;
      row = random_row();
      send_item(row);
    end
    s_axis_tvalid_i <= 1'b0;

    wait (gap_results_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("items: %0d arrivals, %0d queries; %0d results checked", n_arrivals,
             n_queries, n_results);
    $display("cases: %0d table-full drops, %0d absent queries, %0d backward times",
             n_full, n_absent, n_backward);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
